### hdl/gacm_pkg.sv
package gacm_pkg;

  // Defaults of the top level parameters.
  localparam int MAX_SIDE_DEF  = 32;
  localparam int TYPE_BITS_DEF = 3;

  // Fixed field widths.
  localparam int OP_W    = 2;
  localparam int COORD_W = 6;
  localparam int SIZE_W  = 6;
  localparam int TYPE_W  = 3;
  localparam int GRID_W  = 6;
  localparam int SUM_W   = 8;   // holds start + size as a signed value
  localparam int PROD_W  = 2 * GRID_W;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;
  localparam logic [GRID_W-1:0] GRID_RST = GRID_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_CHECK = 2'd0,
    OP_MARK  = 2'd1,
    OP_TRY   = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef struct packed {
    logic [GRID_W-1:0] width;
    logic [GRID_W-1:0] height;
  } cfg_t;

endpackage

### hdl/gacm_cfg.sv
module gacm_cfg
  import gacm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [GRID_W-1:0] width_q, width_d;
  logic [GRID_W-1:0] height_q, height_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_GRID_WIDTH:  width_d  = pwdata[GRID_W-1:0];
        REG_GRID_HEIGHT: height_d = pwdata[GRID_W-1:0];
        default:         width_d  = width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GRID_RST;
      height_q <= GRID_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH:  prdata = PDATA_W'(width_q);
      REG_GRID_HEIGHT: prdata = PDATA_W'(height_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;

endmodule

### hdl/gacm_store.sv
module gacm_store
  import gacm_pkg::*;
#(
  parameter int DEPTH     = MAX_SIDE_DEF * MAX_SIDE_DEF,
  parameter int TYPE_BITS = TYPE_BITS_DEF,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [AW-1:0]        addr_i,
  input  logic [TYPE_BITS-1:0] wdata_i,
  output logic [TYPE_BITS-1:0] rdata_o,
  output logic                 clearing_o
);

  logic [TYPE_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]        clr_q, clr_d;
  logic                 clearing_q, clearing_d;
  logic                 wr;
  logic [AW-1:0]        waddr;
  logic [TYPE_BITS-1:0] wdata;

  // After reset every cell is written to type zero, one per cycle.
  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_d = clr_q + AW'(1);
      if (clr_q == AW'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_q      <= clr_d;
      clearing_q <= clearing_d;
    end
  end

  assign wr    = clearing_q | we_i;
  assign waddr = clearing_q ? clr_q : addr_i;
  assign wdata = clearing_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[waddr] <= wdata;
    end
    rdata_o <= mem[addr_i];
  end

  assign clearing_o = clearing_q;

endmodule

### hdl/gacm_seq.sv
module gacm_seq
  import gacm_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int TYPE_BITS = TYPE_BITS_DEF,
  parameter int AW        = $clog2(MAX_SIDE * MAX_SIDE)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 store_busy_i,
  input  logic                 start_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [COORD_W-1:0]   start_x_i,
  input  logic [COORD_W-1:0]   start_y_i,
  input  logic [SIZE_W-1:0]    size_x_i,
  input  logic [SIZE_W-1:0]    size_y_i,
  input  logic [TYPE_W-1:0]    required_type_i,
  input  logic [TYPE_W-1:0]    placement_type_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic                 success_o,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_addr_o,
  output logic [TYPE_BITS-1:0] mem_wdata_o,
  input  logic [TYPE_BITS-1:0] mem_rdata_i
);

  localparam int SAT   = (MAX_SIDE < 63) ? MAX_SIDE : 63;
  localparam int CMP_W = (TYPE_BITS > TYPE_W) ? TYPE_BITS : TYPE_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_MARK  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d, succ_q, succ_d;
  logic   fail_q, fail_d, rd_pend_q, rd_pend_d;

  // Captured request.
  op_e                       op_q;
  logic signed [COORD_W-1:0] sx_q, sy_q;
  logic [SIZE_W-1:0]         szx_q, szy_q;
  logic [TYPE_W-1:0]         req_q, plc_q;

  // Clipped scan window and walking position.
  logic [COORD_W-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [AW-1:0]      base_q, base_d, base0_q;

  logic [GRID_W-1:0]       w_eff, h_eff;
  logic signed [SUM_W-1:0] sx_s, sy_s, ex_s, ey_s, w_s, h_s;
  logic signed [SUM_W-1:0] cx0, cx1, cy0, cy1;
  logic                    empty, prelim;
  logic [PROD_W-1:0]       prod;
  logic                    accept, last_x, last_y, mismatch, ok;

  assign w_eff = (cfg_i.width > GRID_W'(SAT)) ? GRID_W'(SAT) : cfg_i.width;
  assign h_eff = (cfg_i.height > GRID_W'(SAT)) ? GRID_W'(SAT) : cfg_i.height;

  assign sx_s = SUM_W'(sx_q);
  assign sy_s = SUM_W'(sy_q);
  assign ex_s = sx_s + signed'(SUM_W'(szx_q));
  assign ey_s = sy_s + signed'(SUM_W'(szy_q));
  assign w_s  = signed'(SUM_W'(w_eff));
  assign h_s  = signed'(SUM_W'(h_eff));

  // Intersection of the rectangle with the grid.
  assign cx0 = (sx_s < 0) ? '0 : sx_s;
  assign cy0 = (sy_s < 0) ? '0 : sy_s;
  assign cx1 = (ex_s < w_s) ? ex_s : w_s;
  assign cy1 = (ey_s < h_s) ? ey_s : h_s;
  assign empty = (cx0 >= cx1) || (cy0 >= cy1);

  // Bounds test of check and try-place: rectangle inside the grid and start cell valid.
  assign prelim = (ex_s <= w_s) && (ey_s <= h_s) && (sx_s >= 0) && (sy_s >= 0) &&
                  (sx_s < w_s) && (sy_s < h_s);

  assign prod = PROD_W'(cy0[COORD_W-1:0]) * PROD_W'(w_eff);

  assign accept     = start_i & ~busy_o;
  assign busy_o     = (state_q != ST_IDLE) | store_busy_i;
  assign last_x     = (x_q + COORD_W'(1)) == x1_q;
  assign last_y     = (y_q + COORD_W'(1)) == y1_q;
  assign mismatch   = CMP_W'(mem_rdata_i) != CMP_W'(req_q);
  assign ok         = ~fail_q & ~mismatch;
  assign mem_addr_o = base_q + AW'(x_q);
  assign mem_wdata_o = TYPE_BITS'(CMP_W'(plc_q));

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    succ_d    = succ_q;
    fail_d    = fail_q;
    rd_pend_d = 1'b0;
    x_d       = x_q;
    y_d       = y_q;
    base_d    = base_q;
    mem_we_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        x_d    = cx0[COORD_W-1:0];
        y_d    = cy0[COORD_W-1:0];
        base_d = AW'(prod);
        fail_d = 1'b0;
        if (op_q == OP_MARK) begin
          if (empty) begin
            done_d  = 1'b1;
            succ_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MARK;
          end
        end else if (!prelim || empty) begin
          // An empty rectangle that passes the bounds test succeeds and marks nothing.
          done_d  = 1'b1;
          succ_d  = prelim;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        rd_pend_d = 1'b1;
        if (rd_pend_q && mismatch) begin
          fail_d = 1'b1;
        end
        if (last_x) begin
          x_d    = x0_q;
          y_d    = y_q + COORD_W'(1);
          base_d = base_q + AW'(w_eff);
          if (last_y) begin
            state_d = ST_DRAIN;
          end
        end else begin
          x_d = x_q + COORD_W'(1);
        end
      end
      ST_DRAIN: begin
        if (op_q == OP_TRY && ok) begin
          x_d     = x0_q;
          y_d     = y0_q;
          base_d  = base0_q;
          state_d = ST_MARK;
        end else begin
          done_d  = 1'b1;
          succ_d  = ok;
          state_d = ST_IDLE;
        end
      end
      ST_MARK: begin
        mem_we_o = 1'b1;
        if (last_x) begin
          x_d    = x0_q;
          y_d    = y_q + COORD_W'(1);
          base_d = base_q + AW'(w_eff);
          if (last_y) begin
            done_d  = 1'b1;
            succ_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          x_d = x_q + COORD_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      succ_q    <= 1'b0;
      fail_q    <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      succ_q    <= succ_d;
      fail_q    <= fail_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      sx_q  <= start_x_i;
      sy_q  <= start_y_i;
      szx_q <= size_x_i;
      szy_q <= size_y_i;
      req_q <= required_type_i;
      plc_q <= placement_type_i;
    end
    if (state_q == ST_SETUP) begin
      x0_q    <= cx0[COORD_W-1:0];
      x1_q    <= cx1[COORD_W-1:0];
      y0_q    <= cy0[COORD_W-1:0];
      y1_q    <= cy1[COORD_W-1:0];
      base0_q <= AW'(prod);
    end
    x_q    <= x_d;
    y_q    <= y_d;
    base_q <= base_d;
  end

  assign done_o    = done_q;
  assign success_o = succ_q;

endmodule

### hdl/grid_area_check_and_mark_core.sv
// Rectangle check and mark on a row-major grid of cell-type codes.
//
// A request is accepted when start_i is high and busy_o is low. The block then
// walks the part of the rectangle that lies in the grid one cell per cycle,
// reading the cell store for a check and writing it for a mark. A try-place
// checks every cell first and, if all match, walks the rectangle a second time to mark it.
// When the request finishes, done_o is high for exactly one cycle with
// success_o, and busy_o falls in that same cycle, so the next request may be
// accepted right away. The receiver cannot stall; the result is simply there
// for that one cycle.
// From the accepting edge, a request goes through ST_SETUP, then ST_CHECK and ST_DRAIN
// for a check or try-place that reads cells, then ST_MARK for a mark or a passing
// try-place. The walk is set by the single port of the cell store, which serves one
// cell per cycle.
// Grid width and height are written over the APB port at addresses 0 and 4; the user must
// write them only while the block is idle, which the block itself does not check. Both reset to 32.
// After reset the store is cleared to type zero, one cell per cycle, over all
// MAX_SIDE*MAX_SIDE cells; busy_o is high meanwhile.
module grid_area_check_and_mark_core
  import gacm_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int TYPE_BITS = TYPE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [COORD_W-1:0] start_x_i,
  input  logic [COORD_W-1:0] start_y_i,
  input  logic [SIZE_W-1:0]  size_x_i,
  input  logic [SIZE_W-1:0]  size_y_i,
  input  logic [TYPE_W-1:0]  required_type_i,
  input  logic [TYPE_W-1:0]  placement_type_i,
  output logic               done_o,
  output logic               success_o
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  cfg_t                 cfg;
  logic                 clearing;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [TYPE_BITS-1:0] mem_wdata, mem_rdata;

  gacm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gacm_store #(
    .DEPTH     (DEPTH),
    .TYPE_BITS (TYPE_BITS),
    .AW        (AW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (mem_we),
    .addr_i     (mem_addr),
    .wdata_i    (mem_wdata),
    .rdata_o    (mem_rdata),
    .clearing_o (clearing)
  );

  gacm_seq #(
    .MAX_SIDE  (MAX_SIDE),
    .TYPE_BITS (TYPE_BITS),
    .AW        (AW)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .store_busy_i     (clearing),
    .start_i          (start_i),
    .operation_i      (operation_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .size_x_i         (size_x_i),
    .size_y_i         (size_y_i),
    .required_type_i  (required_type_i),
    .placement_type_i (placement_type_i),
    .busy_o           (busy_o),
    .done_o           (done_o),
    .success_o        (success_o),
    .mem_we_o         (mem_we),
    .mem_addr_o       (mem_addr),
    .mem_wdata_o      (mem_wdata),
    .mem_rdata_i      (mem_rdata)
  );

endmodule

### bench/tb_grid_area_check_and_mark_core.sv
module tb_grid_area_check_and_mark_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gacm_pkg::*;

  localparam int CELLS          = MAX_SIDE_DEF * MAX_SIDE_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 16;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 34;

  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [SIZE_W-1:0]  size_x;
    logic [SIZE_W-1:0]  size_y;
    logic [TYPE_W-1:0]  required;
    logic [TYPE_W-1:0]  placement;
    logic               drain_first;
  } area_req_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               psel             = 1'b0;
  logic               penable          = 1'b0;
  logic               pwrite           = 1'b0;
  logic [PADDR_W-1:0] paddr            = '0;
  logic [PDATA_W-1:0] pwdata           = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               start_i          = 1'b0;
  logic               busy_o;
  logic [OP_W-1:0]    operation_i      = '0;
  logic [COORD_W-1:0] start_x_i        = '0;
  logic [COORD_W-1:0] start_y_i        = '0;
  logic [SIZE_W-1:0]  size_x_i         = '0;
  logic [SIZE_W-1:0]  size_y_i         = '0;
  logic [TYPE_W-1:0]  required_type_i  = '0;
  logic [TYPE_W-1:0]  placement_type_i = '0;
  logic               done_o;
  logic               success_o;

  // Shadow copy of the grid, advanced at each accepted transaction, and of its geometry as written.
  logic [TYPE_W-1:0] cell_types [CELLS];
  logic [GRID_W-1:0] grid_w_cfg = GRID_RST;
  logic [GRID_W-1:0] grid_h_cfg = GRID_RST;

  area_req_t pending_reqs [$];
  bit        expected_success [$];
  area_req_t offered_req;
  int        sender_idle_pct = 0;
  int        mismatches      = 0;
  int        quiet_cycles    = 0;

  grid_area_check_and_mark_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .size_x_i         (size_x_i),
    .size_y_i         (size_y_i),
    .required_type_i  (required_type_i),
    .placement_type_i (placement_type_i),
    .done_o           (done_o),
    .success_o        (success_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int eff_side(logic [GRID_W-1:0] side);
    return (side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(side);
  endfunction

  function automatic bit area_free(int sx, int sy, int szx, int szy, logic [TYPE_W-1:0] need);
    int w;
    int h;
    w = eff_side(grid_w_cfg);
    h = eff_side(grid_h_cfg);
    if (sx + szx > w || sy + szy > h) return 1'b0;
    if (sx < 0 || sx >= w || sy < 0 || sy >= h) return 1'b0;
    for (int y = 0; y < szy; y++) begin
      for (int x = 0; x < szx; x++) begin
        if (cell_types[(sy + y) * w + sx + x] != need) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Cells of the rectangle that fall outside the grid are skipped.
  function automatic void fill_area(int sx, int sy, int szx, int szy, logic [TYPE_W-1:0] kind);
    int w;
    int h;
    int cx;
    int cy;
    w = eff_side(grid_w_cfg);
    h = eff_side(grid_h_cfg);
    for (int y = 0; y < szy; y++) begin
      for (int x = 0; x < szx; x++) begin
        cx = sx + x;
        cy = sy + y;
        if (cx >= 0 && cx < w && cy >= 0 && cy < h) cell_types[cy * w + cx] = kind;
      end
    end
  endfunction

  function automatic bit predict_success(area_req_t r);
    int sx;
    int sy;
    int szx;
    int szy;
    bit ok;
    sx  = $signed(r.start_x);
    sy  = $signed(r.start_y);
    szx = int'(r.size_x);
    szy = int'(r.size_y);
    case (r.op)
      OP_MARK: begin
        fill_area(sx, sy, szx, szy, r.placement);
        ok = 1'b1;
      end
      OP_TRY: begin
        ok = area_free(sx, sy, szx, szy, r.required);
        if (ok) fill_area(sx, sy, szx, szy, r.placement);
      end
      default: begin
        ok = area_free(sx, sy, szx, szy, r.required);
      end
    endcase
    return ok;
  endfunction

  function automatic void push_req(op_e op, int sx, int sy, int szx, int szy, int need,
                                   int put, bit drain);
    area_req_t r;
    r.op          = op;
    r.start_x     = COORD_W'(sx);
    r.start_y     = COORD_W'(sy);
    r.size_x      = SIZE_W'(szx);
    r.size_y      = SIZE_W'(szy);
    r.required    = TYPE_W'(need);
    r.placement   = TYPE_W'(put);
    r.drain_first = drain;
    pending_reqs.push_back(r);
  endfunction

  // Mostly small in-range extents, sometimes any extent up to the whole room or one cell too many.
  function automatic int pick_extent(int room);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return room + 1;
    if (pick == 1) return $urandom_range(0, room);
    return $urandom_range(0, (room < 4) ? room : 4);
  endfunction

  function automatic area_req_t make_random_req(logic [TYPE_W-1:0] background);
    area_req_t r;
    int w;
    int h;
    int sx;
    int sy;
    int op_pick;
    w = eff_side(grid_w_cfg);
    h = eff_side(grid_h_cfg);
    op_pick = $urandom_range(0, 9);
    r.op = (op_pick < 3) ? OP_CHECK : (op_pick < 5) ? OP_MARK : (op_pick < 9) ? OP_TRY : OP_RSVD;
    r.placement   = TYPE_W'($urandom);
    r.drain_first = ($urandom_range(0, 39) == 0);
    if (w > 0 && h > 0 && $urandom_range(0, 99) < 70) begin
      sx = $urandom_range(0, w - 1);
      sy = $urandom_range(0, h - 1);
      r.start_x  = COORD_W'(sx);
      r.start_y  = COORD_W'(sy);
      r.size_x   = SIZE_W'(pick_extent(w - sx));
      r.size_y   = SIZE_W'(pick_extent(h - sy));
      r.required = ($urandom_range(0, 3) != 0) ? background : TYPE_W'($urandom);
    end else begin
      r.start_x  = COORD_W'($urandom);
      r.start_y  = COORD_W'($urandom);
      r.size_x   = SIZE_W'($urandom);
      r.size_y   = SIZE_W'($urandom);
      r.required = TYPE_W'($urandom);
    end
    return r;
  endfunction

  // The prediction is made at the accepting edge, so the shadow grid follows
  // the order in which the block takes transactions.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) expected_success.push_back(predict_success(offered_req));
      if (!(start_i && busy_o)) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct &&
            !(pending_reqs[0].drain_first && expected_success.size() != 0)) begin
          offered_req      = pending_reqs.pop_front();
          operation_i      <= offered_req.op;
          start_x_i        <= offered_req.start_x;
          start_y_i        <= offered_req.start_y;
          size_x_i         <= offered_req.size_x;
          size_y_i         <= offered_req.size_y;
          required_type_i  <= offered_req.required;
          placement_type_i <= offered_req.placement;
          start_i          <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_success.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, actual success %0b",
                 $realtime, success_o);
        mismatches++;
      end else begin
        if (success_o !== expected_success[0]) begin
          $display("%0t: success mismatch, expected %0b, actual %0b",
                   $realtime, expected_success[0], success_o);
          mismatches++;
        end
        void'(expected_success.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || start_i || busy_o || expected_success.size() != 0);
  endtask

  task automatic write_grid_reg(input logic [0:0] reg_idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    pwdata  <= PDATA_W'(GRID_W'(value));
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_idx == REG_GRID_WIDTH) grid_w_cfg = GRID_W'(value);
    else grid_h_cfg = GRID_W'(value);
    @(posedge clk_i);
  endtask

  initial begin
    int phase_w [PHASES] = '{32, 63, 1, 0, 9, 5, -1, 32};
    int phase_h [PHASES] = '{32, 63, 1, 7, 0, 13, -1, 17};
    int phase_idle [PHASES] = '{0, 76, 0, 22, 0, 76, 22, 0};
    logic [TYPE_W-1:0] background;
    int w;
    int h;

    foreach (cell_types[i]) cell_types[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed transactions on the 32 by 32 grid, cleared to type zero.
    push_req(OP_CHECK, 0, 0, 32, 32, 0, 0, 0);
    push_req(OP_CHECK, 0, 0, 32, 33, 0, 0, 0);
    push_req(OP_CHECK, -1, 0, 1, 1, 0, 0, 0);
    push_req(OP_CHECK, -32, -32, 63, 63, 0, 0, 0);
    push_req(OP_CHECK, 31, 31, 1, 1, 0, 0, 0);
    push_req(OP_CHECK, 31, 31, 0, 0, 7, 0, 0);
    push_req(OP_CHECK, 5, 5, 0, 3, 7, 0, 0);
    push_req(OP_MARK, -2, -2, 4, 4, 0, 7, 0);
    push_req(OP_CHECK, 0, 0, 2, 2, 7, 0, 0);
    push_req(OP_CHECK, 0, 0, 3, 3, 7, 0, 0);
    push_req(OP_MARK, 30, 30, 63, 63, 0, 5, 0);
    push_req(OP_TRY, 30, 30, 2, 2, 5, 3, 0);
    push_req(OP_TRY, 30, 30, 2, 2, 5, 6, 0);
    push_req(OP_CHECK, 30, 30, 2, 2, 3, 0, 0);
    push_req(OP_RSVD, 30, 30, 2, 2, 3, 0, 0);
    push_req(OP_CHECK, 30, 30, 2, 2, 3, 0, 0);
    push_req(OP_MARK, 10, 4, 0, 5, 0, 7, 0);
    push_req(OP_TRY, 10, 4, 5, 0, 0, 7, 0);
    push_req(OP_CHECK, 10, 4, 1, 1, 0, 0, 0);
    push_req(OP_MARK, 0, 0, 63, 63, 0, 7, 0);
    push_req(OP_TRY, 0, 0, 32, 32, 7, 0, 0);
    push_req(OP_CHECK, 0, 0, 32, 32, 0, 0, 1);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      w = (phase_w[p] < 0) ? $urandom_range(1, 40) : phase_w[p];
      h = (phase_h[p] < 0) ? $urandom_range(1, 40) : phase_h[p];
      write_grid_reg(REG_GRID_WIDTH, w);
      write_grid_reg(REG_GRID_HEIGHT, h);
      sender_idle_pct = phase_idle[p];
      background = TYPE_W'($urandom);
      // Flood the grid first so that checks against the background type can pass.
      push_req(OP_MARK, 0, 0, 63, 63, 0, int'(background), 0);
      repeat (PHASE_ITEMS) pending_reqs.push_back(make_random_req(background));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
